// ===== rtl/lfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

  // Link codes as they appear on active_link.
  typedef enum logic [1:0] {
    LINK_NONE    = 2'd0,
    LINK_PRIMARY = 2'd1,
    LINK_BACKUP  = 2'd2
  } link_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_GRACE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROBE = 2'd2;

  localparam int unsigned TimeW = 32;

  localparam logic [TimeW-1:0] GRACE_RST = 32'd25000;
  localparam logic [TimeW-1:0] RETRY_RST = 32'd300000;
  localparam logic [TimeW-1:0] PROBE_RST = 32'd5000;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             primary_up;
    logic             service_up;
    logic             backup_up;
    logic             modem_ready;
    logic             reopen_ok;
  } tick_t;

  typedef struct packed {
    logic [1:0] active_link;
    logic       switched;
    logic       probed;
    logic       reopen_requested;
    logic       penalty_on;
  } sel_t;

endpackage

`default_nettype wire

// ===== rtl/lfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick request channel.
interface lfs_tick_if;
  logic          valid;
  logic          ready;
  lfs_pkg::tick_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Selection result channel.
interface lfs_sel_if;
  logic         valid;
  logic         ready;
  lfs_pkg::sel_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/link_failover_selector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Link failover selector. Once per poll tick request it picks the primary link,
// the backup link or no link, and returns one result request per tick in the
// same order. A tick passes through an input register and a result register,
// so its result is presented once it is loaded into the result register; a
// new tick can be taken every cycle unless a result held by the sink stalls
// the pipeline, since all decision logic (a few 32-bit wrapping subtractions
// and compares) sits in one combinational stage between those registers. The
// selector state updates as each tick moves into the result register, so back
// to back ticks see each other's effects exactly as in sequence. Time stamps
// are milliseconds modulo 2^32, and a stored stamp of zero means "not set".
// The three 32-bit registers (grace, retry, probe interval) are written through
// the plain write port and should only be changed while no tick is in flight.
module link_failover_selector_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  lfs_tick_if.sink                                in_req,
  lfs_sel_if.source                               out_res,
  input  wire logic                               cfg_we_i,
  input  wire logic [lfs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [lfs_pkg::TimeW-1:0]          cfg_wdata_i
);

  // Configuration registers.
  logic [lfs_pkg::TimeW-1:0] grace_q, retry_q, probe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q <= lfs_pkg::GRACE_RST;
      retry_q <= lfs_pkg::RETRY_RST;
      probe_q <= lfs_pkg::PROBE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfs_pkg::CFG_GRACE: grace_q <= cfg_wdata_i;
        lfs_pkg::CFG_RETRY: retry_q <= cfg_wdata_i;
        lfs_pkg::CFG_PROBE: probe_q <= cfg_wdata_i;
        default: ;  // Unused index: the write is dropped.
      endcase
    end
  end

  // Pipeline control. The result register loads when it is empty or being
  // drained; the input register then hands its tick forward.
  logic           in_vld_q, out_vld_q;
  lfs_pkg::tick_t tick_q;
  lfs_pkg::sel_t  sel_q, sel_d;
  logic           out_load, advance;

  assign out_load     = !out_vld_q || out_res.ready;
  assign advance      = in_vld_q && out_load;
  assign in_req.ready = !in_vld_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_req.ready) begin
        in_vld_q <= in_req.valid;
      end
      if (out_load) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req.valid && in_req.ready) begin
      tick_q <= in_req.payload;
    end
    if (advance) begin
      sel_q <= sel_d;
    end
  end

  assign out_res.valid   = out_vld_q;
  assign out_res.payload = sel_q;

  // Selector state.
  lfs_pkg::link_e            cur_q, cur_d;
  logic [lfs_pkg::TimeW-1:0] down_since_q, down_since_d;
  logic                      pen_q, pen_d;
  logic [lfs_pkg::TimeW-1:0] pen_time_q, pen_time_d;
  logic [lfs_pkg::TimeW-1:0] last_probe_q, last_probe_d;
  logic                      bok_q, bok_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= lfs_pkg::LINK_NONE;
      down_since_q <= '0;
      pen_q        <= 1'b0;
      pen_time_q   <= '0;
      last_probe_q <= '0;
      bok_q        <= 1'b0;
    end else if (advance) begin
      cur_q        <= cur_d;
      down_since_q <= down_since_d;
      pen_q        <= pen_d;
      pen_time_q   <= pen_time_d;
      last_probe_q <= last_probe_d;
      bok_q        <= bok_d;
    end
  end

  // Decision logic for the tick held in the input register.
  logic [lfs_pkg::TimeW-1:0] now;
  logic [lfs_pkg::TimeW-1:0] down_elapsed, pen_elapsed, probe_elapsed;
  logic                      probed, reopen_req;
  lfs_pkg::link_e            want;

  assign now           = tick_q.now_ms;
  assign probe_elapsed = now - last_probe_q;

  always_comb begin
    down_since_d = down_since_q;
    pen_d        = pen_q;
    pen_time_d   = pen_time_q;
    last_probe_d = last_probe_q;
    bok_d        = bok_q;
    probed       = 1'b0;
    reopen_req   = 1'b0;

    // A primary link that has dropped clears its outage tracking first.
    if (!tick_q.primary_up) begin
      down_since_d = '0;
      pen_d        = 1'b0;
    end

    // While on the primary link, time a service outage against the grace time.
    down_elapsed = now - down_since_d;
    if (cur_q == lfs_pkg::LINK_PRIMARY) begin
      if (tick_q.service_up) begin
        down_since_d = '0;
        pen_d        = 1'b0;
      end else if (down_since_d == '0) begin
        down_since_d = now;
      end else if (!pen_d && (down_elapsed > grace_q)) begin
        pen_d      = 1'b1;
        pen_time_d = now;
      end
    end

    // Lift the penalty once the retry window has passed.
    pen_elapsed = now - pen_time_d;
    if (pen_d && (pen_elapsed > retry_q)) begin
      pen_d        = 1'b0;
      down_since_d = '0;
    end

    if (tick_q.primary_up && !pen_d) begin
      want = lfs_pkg::LINK_PRIMARY;
    end else begin
      // Sample the backup link at most once per probe interval.
      if ((probe_elapsed >= probe_q) || (last_probe_q == '0)) begin
        probed       = 1'b1;
        last_probe_d = now;
        bok_d        = tick_q.backup_up;
        if (!tick_q.backup_up && tick_q.modem_ready) begin
          reopen_req = 1'b1;
          bok_d      = tick_q.reopen_ok;
        end
      end
      if (bok_d) begin
        want = lfs_pkg::LINK_BACKUP;
      end else if (tick_q.primary_up) begin
        want = lfs_pkg::LINK_PRIMARY;
      end else begin
        want = lfs_pkg::LINK_NONE;
      end
    end

    cur_d = want;

    sel_d.active_link      = want;
    sel_d.switched         = (want != cur_q);
    sel_d.probed           = probed;
    sel_d.reopen_requested = reopen_req;
    sel_d.penalty_on       = pen_d;
  end

endmodule

`default_nettype wire
